>>> hw/rtl/bloom_filter_double_hash_core_assert.svh
// Assertion macros for the filter modules; only the controller uses them.
`ifndef BLOOM_FILTER_DOUBLE_HASH_CORE_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BFDH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bloom filter assertion failed");
`define BFDH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bloom filter assertion failed");
`else
`define BFDH_ASSERT(lbl, clk, rst_n, prop)
`define BFDH_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hw/rtl/bfdh_pkg.sv
package bfdh_pkg;

    localparam int FILTER_BITS_DEF = 65536;
    localparam int MAX_HASHES_DEF  = 16;

    localparam int HASH_W      = 64;
    localparam int DIV_RADIX   = 4;
    localparam int DIV_STEPS   = HASH_W / DIV_RADIX;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int NBITS_W     = 17;
    localparam int NHASH_W     = 5;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_BITS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 1'b1;

    localparam logic [NBITS_W-1:0] NBITS_RST = 17'd65536;
    localparam logic [NHASH_W-1:0] NHASH_RST = 5'd7;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [HASH_W-1:0] DJB_START = 64'd5381;

    typedef struct packed {
        logic clear_en;
        logic hash_byte;
        logic start_key;
        logic div_start;
        logic div_step;
        logic mem_access;
        logic check;
        logic out_load;
    } bfdh_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic last_probe;
    } bfdh_status_t;

    // The FNV prime is 2^40 + 0x1B3, so the product is a handful of shifted adds.
    function automatic logic [HASH_W-1:0] fnv_next(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] t;
        t = h ^ {56'd0, b};
        return (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
    endfunction

    function automatic logic [HASH_W-1:0] djb_next(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        return (h << 5) + h + {56'd0, b};
    endfunction

endpackage

>>> hw/rtl/bfdh_ram.sv
module bfdh_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/bfdh_datapath.sv
module bfdh_datapath #(
    parameter int FILTER_BITS = bfdh_pkg::FILTER_BITS_DEF,
    parameter int MAX_HASHES  = bfdh_pkg::MAX_HASHES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bfdh_pkg::bfdh_cmd_t             cmd,
    output bfdh_pkg::bfdh_status_t          status,
    input  logic                            cfg_we,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfdh_pkg::NBITS_W-1:0]    cfg_wdata,
    input  logic                            in_action,
    input  logic [7:0]                      in_key_byte,
    output logic                            out_was_query,
    output logic                            out_maybe_present
);

    localparam int AW = $clog2(FILTER_BITS);
    localparam int HW = bfdh_pkg::HASH_W;
    localparam int NB = bfdh_pkg::NBITS_W;
    localparam int NH = bfdh_pkg::NHASH_W;

    logic [NB-1:0] num_bits_reg;
    logic [NH-1:0] num_hashes_reg;
    logic [HW-1:0] fnv_reg, djb_reg, acc_reg, step_reg, quot_reg;
    logic [NB-1:0] rem_reg, m_reg;
    logic [NH-1:0] k_reg, probe_reg;
    logic [bfdh_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic          all_reg, act_reg, was_query_reg, maybe_reg;
    logic [AW-1:0] clr_reg;

    logic [HW-1:0] fnv_n, djb_n;
    logic [NB-1:0] m_eff, rem_next;
    logic [NH-1:0] k_eff;
    logic [HW-1:0] quot_next;
    logic [NB:0]   trial;

    logic          ram_en, ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_addr;

    assign fnv_n = bfdh_pkg::fnv_next(fnv_reg, in_key_byte);
    assign djb_n = bfdh_pkg::djb_next(djb_reg, in_key_byte);

    always_comb begin
        if (num_bits_reg == '0) begin
            m_eff = NB'(1);
        end else if (32'(num_bits_reg) > 32'(FILTER_BITS)) begin
            m_eff = NB'(FILTER_BITS);
        end else begin
            m_eff = num_bits_reg;
        end
        if (num_hashes_reg == '0) begin
            k_eff = NH'(1);
        end else if (32'(num_hashes_reg) > 32'(MAX_HASHES)) begin
            k_eff = NH'(MAX_HASHES);
        end else begin
            k_eff = num_hashes_reg;
        end
    end

    // Restoring remainder, a few dividend bits per cycle, most significant first.
    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        trial     = '0;
        for (int j = 0; j < bfdh_pkg::DIV_RADIX; j++) begin
            trial     = {rem_next, quot_next[HW-1]};
            quot_next = quot_next << 1;
            if (trial >= {1'b0, m_reg}) begin
                trial = trial - {1'b0, m_reg};
            end
            rem_next = trial[NB-1:0];
        end
    end

    always_comb begin
        ram_en    = cmd.clear_en | cmd.mem_access;
        ram_we    = cmd.clear_en | (cmd.mem_access & ~act_reg);
        ram_addr  = cmd.clear_en ? clr_reg : AW'(rem_reg);
        ram_wdata = ~cmd.clear_en;
    end

    bfdh_ram #(
        .WIDTH(1),
        .DEPTH(FILTER_BITS)
    ) u_store (
        .aclk (aclk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_bits_reg   <= bfdh_pkg::NBITS_RST;
            num_hashes_reg <= bfdh_pkg::NHASH_RST;
            fnv_reg        <= bfdh_pkg::FNV_BASIS;
            djb_reg        <= bfdh_pkg::DJB_START;
            clr_reg        <= '0;
        end else begin
            if (cfg_we && cfg_index == bfdh_pkg::REG_NUM_BITS) begin
                num_bits_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == bfdh_pkg::REG_NUM_HASHES) begin
                num_hashes_reg <= cfg_wdata[NH-1:0];
            end
            if (cmd.start_key) begin
                fnv_reg <= bfdh_pkg::FNV_BASIS;
                djb_reg <= bfdh_pkg::DJB_START;
            end else if (cmd.hash_byte) begin
                fnv_reg <= fnv_n;
                djb_reg <= djb_n;
            end
            if (cmd.clear_en) begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_key) begin
            acc_reg   <= fnv_n;
            step_reg  <= djb_n;
            act_reg   <= in_action;
            m_reg     <= m_eff;
            k_reg     <= k_eff;
            probe_reg <= '0;
            all_reg   <= 1'b1;
        end
        if (cmd.div_start) begin
            quot_reg    <= acc_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            quot_reg    <= quot_next;
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.check) begin
            if (act_reg && !ram_rdata) begin
                all_reg <= 1'b0;
            end
            acc_reg   <= acc_reg + step_reg;
            probe_reg <= probe_reg + 1'b1;
        end
        if (cmd.out_load) begin
            was_query_reg <= act_reg;
            maybe_reg     <= act_reg & all_reg;
        end
    end

    assign status.clear_done = (clr_reg == AW'(FILTER_BITS - 1));
    assign status.div_done   = (div_cnt_reg == bfdh_pkg::DIV_CNT_W'(bfdh_pkg::DIV_STEPS - 1));
    assign status.last_probe = (probe_reg == k_reg - 1'b1);

    assign out_was_query     = was_query_reg;
    assign out_maybe_present = maybe_reg;

endmodule

>>> hw/rtl/bfdh_ctrl.sv
`include "bloom_filter_double_hash_core_assert.svh"

module bfdh_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tlast,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output bfdh_pkg::bfdh_cmd_t    cmd,
    input  bfdh_pkg::bfdh_status_t status
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_PREP   = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_ACCESS = 7'b0010000,
        ST_CHECK  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.hash_byte = 1'b1;
                    if (s_tlast) begin
                        cmd.start_key = 1'b1;
                        state_next    = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                cmd.mem_access = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = status.last_probe ? ST_FINISH : ST_PREP;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    // A waiting result is never overwritten by the next one.
    `BFDH_ASSERT(a_no_overwrite, aclk, aresetn, cmd.out_load |-> (!m_valid_reg || m_tready))
    // The final byte of a key always starts the probe sequence.
    `BFDH_ASSERT(a_last_starts, aclk, aresetn,
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == ST_PREP))
    // A store access follows a finished remainder and nothing else.
    `BFDH_ASSERT(a_access_after_div, aclk, aresetn,
        (state_reg == ST_ACCESS) |-> ($past(state_reg) == ST_DIV))

endmodule

>>> hw/rtl/bloom_filter_double_hash_core.sv
// Bloom filter keyed one byte at a time, probed by double hashing.
// Input channel s_*: one key byte per item in s_tdata, s_tlast marks the
// final byte, s_tuser gives the action of the key (0 insert, 1 query); only
// the action given with the final byte counts. Output channel m_*: one item
// per key, m_tuser says it answers a query, m_tdata bit 0 is maybe present.
// Non-final bytes are taken while the block is idle. After the final byte the block
// runs k probes, each made of a load, the steps of the remainder unit
// (four bits of the 64-bit probe hash per cycle), a store access and a
// check. Input is not taken while probes run. The result sits in an output
// register, so a stalled receiver blocks input only when a further key
// finishes before the previous result has been taken.
// After reset all FILTER_BITS bits of the store are cleared, one bit per cycle;
// no item is taken meanwhile, and configuration writes are taken at any time.
module bloom_filter_double_hash_core #(
    parameter int FILTER_BITS = bfdh_pkg::FILTER_BITS_DEF,
    parameter int MAX_HASHES  = bfdh_pkg::MAX_HASHES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] key_byte
    input  logic                           s_tlast,   // last_byte
    input  logic                           s_tuser,   // action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [0] maybe_present, zero fill
    output logic                           m_tuser,   // was_query
    input  logic                           cfg_we,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfdh_pkg::NBITS_W-1:0]   cfg_wdata
);

    bfdh_pkg::bfdh_cmd_t    cmd;
    bfdh_pkg::bfdh_status_t status;
    logic                   maybe_present;

    bfdh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tlast (s_tlast),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd),
        .status  (status)
    );

    bfdh_datapath #(
        .FILTER_BITS(FILTER_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_action        (s_tuser),
        .in_key_byte      (s_tdata),
        .out_was_query    (m_tuser),
        .out_maybe_present(maybe_present)
    );

    assign m_tdata = {7'd0, maybe_present};

endmodule
